FILE: rtl/ltfs_pkg.sv
// Package for the lower-triangular forward substitution unit.
// Holds sizes, status codes, word types and controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ltfs_pkg;

	// Number of rows the solution store holds.
	localparam int MAX_ORDER = 256;
	// Row and column counters must hold MAX_ORDER itself.
	localparam int CNT_W = $clog2(MAX_ORDER + 1);
	localparam int ADDR_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int DATA_W = 32;
	localparam int ACC_W = 64;
	localparam int DIV_STEPS = ACC_W;
	localparam int DCNT_W = $clog2(DIV_STEPS);
	localparam int ROW_IDX_W = 8;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_ZERO_PIVOT = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;
	localparam logic [1:0] STAT_BEYOND = 2'd3;

	typedef struct packed {
		logic signed [31:0] coef;
		logic signed [31:0] rhs;
		logic row_end;
		logic new_system;
	} src_word_t;

	typedef struct packed {
		logic [7:0] row_index;
		logic signed [31:0] solution;
		logic [1:0] status;
	} res_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_ACC,
		ST_NEG,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic mul;
		logic mac_add;
		logic col_inc;
		logic num;
		logic div_init;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic row_end;
		logic do_mac;
		logic beyond;
		logic zero_pivot;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/lower_triangular_forward_substitution_unit.sv
// Off-diagonal word: only the column counter advances when nothing is accumulated, else store read, multiply, add.
// Diagonal word: numerator, then the 64-step radix-2 divider, then the result register.
// Zero pivot or row beyond capacity: result written with no divide.
// One word at a time; a waiting result does not block later off-diagonal words.
// arst_n clears the controller, counters, accumulator and result valid; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lower_triangular_forward_substitution_unit
	import ltfs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic src_valid,
	output logic src_stall,
	input wire src_word_t src_data,
	output logic res_valid,
	input wire logic res_stall,
	output res_word_t res_data
);

	cmd_t cmd;
	sts_t sts;
	logic busy;

	ltfs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.sts(sts),
		.busy(busy),
		.cmd(cmd)
	);

	ltfs_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.src_data(src_data),
		.res_stall(res_stall),
		.sts(sts),
		.res_valid(res_valid),
		.res_data(res_data)
	);

	assign src_stall = busy;

endmodule

`default_nettype wire

FILE: rtl/ltfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ltfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ltfs_ctrl.sv
// Controller state machine for the forward substitution unit.
// Sequences load, multiply-accumulate, numerator, divide and result steps.
// Depends on ltfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ltfs_ctrl
	import ltfs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic src_valid,
	input wire sts_t sts,
	output logic busy,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (src_valid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!sts.row_end) begin
					state_nxt = sts.do_mac ? ST_MUL : ST_IDLE;
				end else if (sts.beyond || sts.zero_pivot) begin
					state_nxt = ST_FINISH;
				end else begin
					state_nxt = ST_NEG;
				end
			end
			ST_MUL: state_nxt = ST_ACC;
			ST_ACC: state_nxt = ST_IDLE;
			ST_NEG: state_nxt = ST_DIV;
			ST_DIV: begin
				if (sts.div_last) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = src_valid;
			end
			ST_EXEC: begin
				if (!sts.row_end) begin
					cmd.rd_en = sts.do_mac;
					cmd.col_inc = !sts.do_mac;
				end else begin
					cmd.num = !(sts.beyond || sts.zero_pivot);
				end
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_ACC: begin
				cmd.mac_add = 1'b1;
				cmd.col_inc = 1'b1;
			end
			ST_NEG: cmd.div_init = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_FINISH: cmd.finish = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/ltfs_dp.sv
// Datapath for the forward substitution unit: counters, solution store,
// multiplier, saturating accumulator, radix-2 divider and result register.
// Depends on ltfs_pkg and ltfs_ram.
`timescale 1ns / 1ps
`default_nettype none

module ltfs_dp
	import ltfs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	input wire src_word_t src_data,
	input wire logic res_stall,
	output sts_t sts,
	output logic res_valid,
	output res_word_t res_data
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ORDER);
	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [ACC_W-1:0] POS_LIM = ACC_W'(32'h7FFF_FFFF);
	localparam logic [ACC_W-1:0] NEG_LIM = ACC_W'(32'h8000_0000);

	src_word_t item_q;
	logic [CNT_W-1:0] row_q;
	logic [CNT_W-1:0] col_q;
	logic signed [ACC_W-1:0] dot_q;
	logic acc_ovf_q;
	logic signed [ACC_W-1:0] num_q;
	logic num_ovf_q;
	logic neg_q;
	logic [ACC_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] den_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic signed [ACC_W-1:0] prod_s1;
	logic out_valid_q;
	res_word_t out_q;

	logic [DATA_W-1:0] ram_rdata;
	logic ram_we;
	logic [DATA_W-1:0] ram_wdata;

	logic signed [ACC_W-1:0] sum;
	logic sum_ovf;
	logic signed [ACC_W-1:0] rhs_ext;
	logic signed [ACC_W-1:0] diff;
	logic diff_ovf;
	logic [DATA_W:0] rem_sh;
	logic [DATA_W+1:0] trial;
	logic ge;
	logic [DATA_W-1:0] sol_div;
	logic quo_ovf;
	logic [DATA_W-1:0] sol;
	logic [1:0] stat;

	assign sts.row_end = item_q.row_end;
	assign sts.beyond = row_q >= MAX_CNT;
	assign sts.do_mac = (row_q < MAX_CNT) && (col_q < row_q);
	assign sts.zero_pivot = item_q.coef == '0;
	assign sts.div_last = div_cnt_q == DCNT_W'(DIV_STEPS - 1);
	assign sts.out_free = !out_valid_q || !res_stall;

	// Saturating accumulate of one product.
	assign sum = dot_q + prod_s1;
	assign sum_ovf = (dot_q[ACC_W-1] == prod_s1[ACC_W-1]) && (sum[ACC_W-1] != dot_q[ACC_W-1]);

	// Numerator (rhs << 16) - dot in Q48.16 with saturation.
	assign rhs_ext = {{16{item_q.rhs[31]}}, item_q.rhs, 16'h0000};
	assign diff = rhs_ext - dot_q;
	assign diff_ovf = (rhs_ext[ACC_W-1] != dot_q[ACC_W-1]) && (diff[ACC_W-1] != rhs_ext[ACC_W-1]);

	// One restoring divide step on magnitudes.
	assign rem_sh = {rem_q, quo_q[ACC_W-1]};
	assign trial = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge = !trial[DATA_W+1];

	always_comb begin
		quo_ovf = 1'b0;
		if (neg_q) begin
			if (quo_q > NEG_LIM) begin
				quo_ovf = 1'b1;
				sol_div = 32'h8000_0000;
			end else begin
				sol_div = 32'h0 - quo_q[DATA_W-1:0];
			end
		end else begin
			if (quo_q > POS_LIM) begin
				quo_ovf = 1'b1;
				sol_div = 32'h7FFF_FFFF;
			end else begin
				sol_div = quo_q[DATA_W-1:0];
			end
		end
	end

	// Capacity first, then zero pivot, then overflow.
	always_comb begin
		priority if (sts.beyond) begin
			stat = STAT_BEYOND;
			sol = '0;
		end else if (sts.zero_pivot) begin
			stat = STAT_ZERO_PIVOT;
			sol = '0;
		end else begin
			stat = (num_ovf_q || quo_ovf) ? STAT_OVERFLOW : STAT_OK;
			sol = sol_div;
		end
	end

	assign ram_we = cmd.finish && !sts.beyond;
	assign ram_wdata = sol;

	ltfs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ORDER)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(row_q[ADDR_W-1:0]),
		.wdata(ram_wdata),
		.re(cmd.rd_en),
		.raddr(col_q[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			dot_q <= '0;
			acc_ovf_q <= 1'b0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && src_data.new_system) begin
				row_q <= '0;
				col_q <= '0;
				dot_q <= '0;
				acc_ovf_q <= 1'b0;
			end
			if (cmd.mac_add) begin
				if (sum_ovf) begin
					dot_q <= dot_q[ACC_W-1] ? ACC_MIN : ACC_MAX;
					acc_ovf_q <= 1'b1;
				end else begin
					dot_q <= sum;
				end
			end
			if (cmd.col_inc && col_q < MAX_CNT) begin
				col_q <= col_q + 1'b1;
			end
			if (cmd.div_init) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			if (cmd.finish) begin
				if (row_q < MAX_CNT) begin
					row_q <= row_q + 1'b1;
				end
				col_q <= '0;
				dot_q <= '0;
				acc_ovf_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= src_data;
		end
		if (cmd.mul) begin
			prod_s1 <= $signed(item_q.coef) * $signed(ram_rdata);
		end
		if (cmd.num) begin
			if (diff_ovf) begin
				num_q <= rhs_ext[ACC_W-1] ? ACC_MIN : ACC_MAX;
			end else begin
				num_q <= diff;
			end
			num_ovf_q <= diff_ovf || acc_ovf_q;
		end
		if (cmd.div_init) begin
			quo_q <= num_q[ACC_W-1] ? (ACC_W'(0) - num_q) : num_q;
			den_q <= item_q.coef[31] ? (DATA_W'(0) - item_q.coef) : item_q.coef;
			neg_q <= num_q[ACC_W-1] ^ item_q.coef[31];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[ACC_W-2:0], ge};
			rem_q <= ge ? trial[DATA_W-1:0] : rem_sh[DATA_W-1:0];
		end
		if (cmd.finish) begin
			out_q.row_index <= (row_q > CNT_W'(255)) ? 8'd255 : row_q[ROW_IDX_W-1:0];
			out_q.solution <= sol;
			out_q.status <= stat;
		end
	end

	assign res_valid = out_valid_q;
	assign res_data = out_q;

endmodule

`default_nettype wire

FILE: rtl/ltfs_chk.sv
// Port-level checker for the forward substitution unit, with its bind.
// Depends on ltfs_pkg and lower_triangular_forward_substitution_unit.
`timescale 1ns / 1ps
`default_nettype none

module ltfs_chk
	import ltfs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic src_valid,
	input wire logic src_stall,
	input wire logic res_valid,
	input wire logic res_stall,
	input wire res_word_t res_data
);

	// A stalled result word stays valid and unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result word changed while stalled");

	// Rows flagged for zero pivot or capacity carry a zero solution.
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status == STAT_ZERO_PIVOT || res_data.status == STAT_BEYOND)
		|-> res_data.solution == '0)
		else $error("flagged row with nonzero solution");

	// After taking a word the unit is busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> src_stall)
		else $error("word accepted in back-to-back cycles");

	// A new result is produced only while a word is being worked on.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(src_stall))
		else $error("result appeared while idle");

endmodule

bind lower_triangular_forward_substitution_unit ltfs_chk u_ltfs_chk (.*);

`default_nettype wire
